@@ hw/rtl/g4fbw_pkg.sv @@
package g4fbw_pkg;

  // Framebuffer geometry.
  localparam int FB_AW             = 19;
  localparam int FB_DW             = 8;
  localparam int MAX_SCREEN_WIDTH  = 1024;
  localparam int MAX_SCREEN_HEIGHT = 1024;

  // Register and counter widths.
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 3;
  localparam int CNT_W     = 10;
  localparam int POS_W     = CFG_W + 1;
  localparam int HALF_W    = CNT_W;
  localparam int GRAY_W    = 4;

  localparam logic [CFG_W-1:0] REGION_MAX = CFG_W'(1024);
  localparam logic [CFG_W-1:0] REGION_MIN = CFG_W'(1);
  localparam logic [CFG_W-1:0] SCREEN_W_CAP =
    (MAX_SCREEN_WIDTH  >= (1 << CFG_W)) ? {CFG_W{1'b1}} : CFG_W'(MAX_SCREEN_WIDTH);
  localparam logic [CFG_W-1:0] SCREEN_H_CAP =
    (MAX_SCREEN_HEIGHT >= (1 << CFG_W)) ? {CFG_W{1'b1}} : CFG_W'(MAX_SCREEN_HEIGHT);

  // Reset values of the registers.
  localparam logic [CFG_W-1:0] SCREEN_W_RST = CFG_W'(960);
  localparam logic [CFG_W-1:0] SCREEN_H_RST = CFG_W'(540);

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GRAY16_ENABLE = 3'd6;

  localparam logic [GRAY_W-1:0] GRAY_WHITE = 4'hF;
  localparam logic [GRAY_W-1:0] GRAY_BLACK = 4'h0;

  typedef struct packed {
    logic [CFG_W-1:0] sw;
    logic [CFG_W-1:0] sh;
  } screen_t;

  // Stage after the input transfer.
  typedef struct packed {
    logic [POS_W-1:0]  xx;
    logic [POS_W-1:0]  yy;
    logic [GRAY_W-1:0] gray;
    logic              last;
  } stage_a_t;

  // Stage holding the row product.
  typedef struct packed {
    logic [FB_AW-1:0]  prod;
    logic [HALF_W-1:0] xhalf;
    logic              on;
    logic              xodd;
    logic [GRAY_W-1:0] gray;
    logic              last;
  } stage_b_t;

  // Stage holding the byte address, which is also the read address.
  typedef struct packed {
    logic [FB_AW-1:0]  addr;
    logic              on;
    logic              xodd;
    logic [GRAY_W-1:0] gray;
    logic              last;
  } stage_c_t;

  // (b + 8) / 17 as a multiply by 241 / 4096; 241 * 17 = 4097, so the error stays
  // far below the smallest fractional step for the range of b.
  function automatic logic [GRAY_W-1:0] gray_level(input logic [7:0] b);
    logic [16:0] p;
    p = ({9'd0, b} + 17'd8) * 17'd241;
    return p[15:12];
  endfunction

endpackage

@@ hw/rtl/g4fbw_ram.sv @@
module g4fbw_ram #(
  parameter int AW = 19,
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [(1 << AW)];

  // Read before write: a read of the address being written returns the old byte.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

@@ hw/rtl/g4fbw_front.sv @@
module g4fbw_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [g4fbw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [g4fbw_pkg::CFG_W-1:0]     cfg_data,
  input  logic                            accept,
  input  logic                            adv,
  input  logic [7:0]                      brightness,
  input  logic                            mono_on,
  output g4fbw_pkg::screen_t              screen,
  output logic                            a_vld,
  output g4fbw_pkg::stage_a_t             a
);

  logic [g4fbw_pkg::CFG_W-1:0] origin_x;
  logic [g4fbw_pkg::CFG_W-1:0] origin_y;
  logic [g4fbw_pkg::CFG_W-1:0] region_width;
  logic [g4fbw_pkg::CFG_W-1:0] region_height;
  logic [g4fbw_pkg::CFG_W-1:0] screen_width;
  logic [g4fbw_pkg::CFG_W-1:0] screen_height;
  logic                        gray16_enable;
  logic [g4fbw_pkg::CNT_W-1:0] col;
  logic [g4fbw_pkg::CNT_W-1:0] row;

  logic [g4fbw_pkg::CFG_W-1:0] rw;
  logic [g4fbw_pkg::CFG_W-1:0] rh;
  logic [g4fbw_pkg::CFG_W-1:0] col_inc;
  logic [g4fbw_pkg::CFG_W-1:0] row_inc;
  logic                        col_end;
  logic                        row_end;
  logic                        restart;
  g4fbw_pkg::stage_a_t         a_next;

  always_comb begin
    if (region_width == '0) begin
      rw = g4fbw_pkg::REGION_MIN;
    end else if (region_width > g4fbw_pkg::REGION_MAX) begin
      rw = g4fbw_pkg::REGION_MAX;
    end else begin
      rw = region_width;
    end
    if (region_height == '0) begin
      rh = g4fbw_pkg::REGION_MIN;
    end else if (region_height > g4fbw_pkg::REGION_MAX) begin
      rh = g4fbw_pkg::REGION_MAX;
    end else begin
      rh = region_height;
    end
  end

  assign screen.sw = (screen_width > g4fbw_pkg::SCREEN_W_CAP) ?
                     g4fbw_pkg::SCREEN_W_CAP : screen_width;
  assign screen.sh = (screen_height > g4fbw_pkg::SCREEN_H_CAP) ?
                     g4fbw_pkg::SCREEN_H_CAP : screen_height;

  assign col_inc = {1'b0, col} + g4fbw_pkg::CFG_W'(1);
  assign row_inc = {1'b0, row} + g4fbw_pkg::CFG_W'(1);
  assign col_end = col_inc >= rw;
  assign row_end = row_inc >= rh;

  // Geometry writes start a new region.
  assign restart = cfg_we && (cfg_index == g4fbw_pkg::REG_ORIGIN_X ||
                              cfg_index == g4fbw_pkg::REG_ORIGIN_Y ||
                              cfg_index == g4fbw_pkg::REG_REGION_WIDTH ||
                              cfg_index == g4fbw_pkg::REG_REGION_HEIGHT);

  always_comb begin
    a_next.xx   = {origin_x[g4fbw_pkg::CFG_W-1], origin_x} + {2'b00, col};
    a_next.yy   = {origin_y[g4fbw_pkg::CFG_W-1], origin_y} + {2'b00, row};
    a_next.gray = gray16_enable ? g4fbw_pkg::gray_level(brightness) :
                  (mono_on ? g4fbw_pkg::GRAY_WHITE : g4fbw_pkg::GRAY_BLACK);
    a_next.last = col_end && row_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x      <= '0;
      origin_y      <= '0;
      region_width  <= g4fbw_pkg::REGION_MIN;
      region_height <= g4fbw_pkg::REGION_MIN;
      screen_width  <= g4fbw_pkg::SCREEN_W_RST;
      screen_height <= g4fbw_pkg::SCREEN_H_RST;
      gray16_enable <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        g4fbw_pkg::REG_ORIGIN_X:      origin_x      <= cfg_data;
        g4fbw_pkg::REG_ORIGIN_Y:      origin_y      <= cfg_data;
        g4fbw_pkg::REG_REGION_WIDTH:  region_width  <= cfg_data;
        g4fbw_pkg::REG_REGION_HEIGHT: region_height <= cfg_data;
        g4fbw_pkg::REG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        g4fbw_pkg::REG_SCREEN_HEIGHT: screen_height <= cfg_data;
        g4fbw_pkg::REG_GRAY16_ENABLE: gray16_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (restart) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (col_end) begin
        col <= '0;
        row <= row_end ? '0 : row_inc[g4fbw_pkg::CNT_W-1:0];
      end else begin
        col <= col_inc[g4fbw_pkg::CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (adv) begin
      a_vld <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a <= a_next;
    end
  end

endmodule

@@ hw/rtl/g4fbw_addr.sv @@
module g4fbw_addr (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  g4fbw_pkg::screen_t  screen,
  input  logic                a_vld,
  input  g4fbw_pkg::stage_a_t a,
  output logic                c_vld,
  output g4fbw_pkg::stage_c_t c
);

  logic                               b_vld;
  g4fbw_pkg::stage_b_t                b;
  g4fbw_pkg::stage_b_t                b_next;
  g4fbw_pkg::stage_c_t                c_next;
  logic [g4fbw_pkg::HALF_W-1:0]       half;
  logic [2*g4fbw_pkg::HALF_W-1:0]     prod_full;
  logic                               x_in;
  logic                               y_in;

  assign half = screen.sw[g4fbw_pkg::CFG_W-1:1];

  // The top bit of each position is its sign.
  assign x_in = !a.xx[g4fbw_pkg::POS_W-1] &&
                (a.xx[g4fbw_pkg::CFG_W-1:0] < screen.sw);
  assign y_in = !a.yy[g4fbw_pkg::POS_W-1] &&
                (a.yy[g4fbw_pkg::CFG_W-1:0] < screen.sh);

  assign prod_full = a.yy[g4fbw_pkg::HALF_W-1:0] * half;

  always_comb begin
    b_next.prod  = prod_full[g4fbw_pkg::FB_AW-1:0];
    b_next.xhalf = a.xx[g4fbw_pkg::HALF_W:1];
    b_next.on    = x_in && y_in;
    b_next.xodd  = a.xx[0];
    b_next.gray  = a.gray;
    b_next.last  = a.last;
  end

  always_comb begin
    c_next.addr = b.on ? (b.prod + {{(g4fbw_pkg::FB_AW-g4fbw_pkg::HALF_W){1'b0}}, b.xhalf})
                       : '0;
    c_next.on   = b.on;
    c_next.xodd = b.xodd;
    c_next.gray = b.gray;
    c_next.last = b.last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
      c_vld <= 1'b0;
    end else if (adv) begin
      b_vld <= a_vld;
      c_vld <= b_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b <= b_next;
      c <= c_next;
    end
  end

endmodule

@@ hw/rtl/gray4_packed_framebuffer_writer_top.sv @@
// Writes a stream of region pixels, in raster order, into a 4-bit packed gray
// framebuffer held in an internal 512 KiB single-port-write, single-port-read RAM.
// One pixel is taken per clock while in_stall is low, and each pixel gives exactly
// one result after its transfer: position, row-stride multiply and byte address
// are registered in turn, then come the RAM read and the nibble merge and
// write-back into the output register. Back-to-back pixels that hit the same byte
// are merged with a forwarded copy of the last byte written. After reset the whole
// memory is cleared one byte per clock; in_stall stays high until that is done,
// while configuration writes are accepted throughout.
module gray4_packed_framebuffer_writer_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [g4fbw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [g4fbw_pkg::CFG_W-1:0]     cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      brightness,
  input  logic                            mono_on,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            written,
  output logic [g4fbw_pkg::FB_AW-1:0]     byte_address,
  output logic [g4fbw_pkg::FB_DW-1:0]     byte_value,
  output logic                            last_pixel
);

  logic                           clearing;
  logic [g4fbw_pkg::FB_AW-1:0]    clr_addr;
  logic                           adv;
  logic                           accept;
  logic                           cfg_we;
  g4fbw_pkg::screen_t             screen;
  logic                           a_vld;
  g4fbw_pkg::stage_a_t            a;
  logic                           c_vld;
  g4fbw_pkg::stage_c_t            c;
  logic                           d_vld;
  g4fbw_pkg::stage_c_t            d;
  logic [g4fbw_pkg::FB_DW-1:0]    rdata;
  logic [g4fbw_pkg::FB_DW-1:0]    base;
  logic [g4fbw_pkg::FB_DW-1:0]    merged;
  logic                           pix_we;
  logic                           ram_we;
  logic [g4fbw_pkg::FB_AW-1:0]    ram_waddr;
  logic [g4fbw_pkg::FB_DW-1:0]    ram_wdata;
  logic                           lw_vld;
  logic [g4fbw_pkg::FB_AW-1:0]    lw_addr;
  logic [g4fbw_pkg::FB_DW-1:0]    lw_data;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  // The whole pipeline moves together whenever the output register can take a result.
  assign adv      = !(out_valid && out_stall);
  assign in_stall = clearing || !adv;
  assign accept   = in_valid && !in_stall;

  g4fbw_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .accept     (accept),
    .adv        (adv),
    .brightness (brightness),
    .mono_on    (mono_on),
    .screen     (screen),
    .a_vld      (a_vld),
    .a          (a)
  );

  g4fbw_addr u_addr (
    .clk    (clk),
    .rst    (rst),
    .adv    (adv),
    .screen (screen),
    .a_vld  (a_vld),
    .a      (a),
    .c_vld  (c_vld),
    .c      (c)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + g4fbw_pkg::FB_AW'(1);
      if (clr_addr == {g4fbw_pkg::FB_AW{1'b1}}) begin
        clearing <= 1'b0;
      end
    end
  end

  // The last byte written is always the newest copy of its address, so it may
  // stand in for a read that raced with its write.
  assign base   = (lw_vld && lw_addr == d.addr) ? lw_data : rdata;
  assign merged = d.xodd ? {d.gray, base[3:0]} : {base[7:4], d.gray};
  assign pix_we = adv && d_vld && d.on;

  assign ram_we    = clearing || pix_we;
  assign ram_waddr = clearing ? clr_addr : d.addr;
  assign ram_wdata = clearing ? '0 : merged;

  g4fbw_ram #(
    .AW (g4fbw_pkg::FB_AW),
    .DW (g4fbw_pkg::FB_DW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (adv),
    .raddr (c.addr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      d_vld  <= 1'b0;
      lw_vld <= 1'b0;
    end else begin
      if (adv) begin
        d_vld <= c_vld;
      end
      if (pix_we) begin
        lw_vld <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d <= c;
    end
    if (pix_we) begin
      lw_addr <= d.addr;
      lw_data <= merged;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      written      <= d.on;
      byte_address <= d.addr;
      byte_value   <= d.on ? merged : '0;
      last_pixel   <= d.last;
    end
  end

endmodule

@@ test/tb_top.sv @@
module tb_top;

  typedef enum logic [1:0] {JOB_PIXEL, JOB_CFG, JOB_DRAIN} job_kind_t;
  typedef enum logic [1:0] {SINK_FREE, SINK_LIGHT, SINK_HEAVY, SINK_PERIODIC} sink_mode_t;

  typedef struct packed {
    job_kind_t                       kind;
    logic [7:0]                      brightness;
    logic                            mono;
    logic [g4fbw_pkg::CFG_IDX_W-1:0] idx;
    logic [g4fbw_pkg::CFG_W-1:0]     data;
  } job_t;

  typedef struct packed {
    logic                        written;
    logic [g4fbw_pkg::FB_AW-1:0] addr;
    logic [g4fbw_pkg::FB_DW-1:0] value;
    logic                        last;
  } fb_update_t;

  // Index 7 has no register behind it.
  localparam logic [g4fbw_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam logic [7:0] GRAY_EDGES [8] = '{8'd0, 8'd255, 8'd8, 8'd9,
                                            8'd127, 8'd128, 8'd25, 8'd26};

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [g4fbw_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [g4fbw_pkg::CFG_W-1:0]     cfg_data = '0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic [7:0]                      brightness = '0;
  logic                            mono_on = 1'b0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic                            written;
  logic [g4fbw_pkg::FB_AW-1:0]     byte_address;
  logic [g4fbw_pkg::FB_DW-1:0]     byte_value;
  logic                            last_pixel;

  gray4_packed_framebuffer_writer_top DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .brightness   (brightness),
    .mono_on      (mono_on),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .written      (written),
    .byte_address (byte_address),
    .byte_value   (byte_value),
    .last_pixel   (last_pixel)
  );

  always #1 clk = ~clk;

  // Shadow of the framebuffer, the region counters and the registers.
  bit   [7:0]                  fb_model [0:(1<<g4fbw_pkg::FB_AW)-1];
  logic [g4fbw_pkg::CNT_W-1:0] col_q = '0;
  logic [g4fbw_pkg::CNT_W-1:0] row_q = '0;
  logic [g4fbw_pkg::CFG_W-1:0] m_org_x = '0;
  logic [g4fbw_pkg::CFG_W-1:0] m_org_y = '0;
  logic [g4fbw_pkg::CFG_W-1:0] m_reg_w = g4fbw_pkg::REGION_MIN;
  logic [g4fbw_pkg::CFG_W-1:0] m_reg_h = g4fbw_pkg::REGION_MIN;
  logic [g4fbw_pkg::CFG_W-1:0] m_scr_w = g4fbw_pkg::SCREEN_W_RST;
  logic [g4fbw_pkg::CFG_W-1:0] m_scr_h = g4fbw_pkg::SCREEN_H_RST;
  logic                        m_gray16 = 1'b0;

  job_t       jobs[$];
  fb_update_t pending_updates[$];
  int         errors = 0;
  logic       in_took = 1'b0;
  logic       cfg_took = 1'b0;
  int         burst_left = 0;
  int         gap_left = 0;
  sink_mode_t sink_mode = SINK_FREE;
  int         sink_left = 0;

  function automatic void apply_cfg(input logic [g4fbw_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [g4fbw_pkg::CFG_W-1:0] data);
    case (idx)
      g4fbw_pkg::REG_ORIGIN_X: begin
        m_org_x = data; col_q = '0; row_q = '0;
      end
      g4fbw_pkg::REG_ORIGIN_Y: begin
        m_org_y = data; col_q = '0; row_q = '0;
      end
      g4fbw_pkg::REG_REGION_WIDTH: begin
        m_reg_w = data; col_q = '0; row_q = '0;
      end
      g4fbw_pkg::REG_REGION_HEIGHT: begin
        m_reg_h = data; col_q = '0; row_q = '0;
      end
      g4fbw_pkg::REG_SCREEN_WIDTH:  m_scr_w = data;
      g4fbw_pkg::REG_SCREEN_HEIGHT: m_scr_h = data;
      g4fbw_pkg::REG_GRAY16_ENABLE: m_gray16 = data[0];
      default: ;
    endcase
  endfunction

  // Merges one pixel into the shadow framebuffer and returns the byte update it causes.
  function automatic fb_update_t store_pixel(input logic [7:0] b, input logic mono);
    int         rw, rh, sw, sh, xx, yy, a;
    logic [3:0] g;
    logic [7:0] v;
    logic       col_end, row_end;
    fb_update_t r;
    rw = (m_reg_w == 0) ? 1 : ((m_reg_w > g4fbw_pkg::REGION_MAX) ?
                               int'(g4fbw_pkg::REGION_MAX) : int'(m_reg_w));
    rh = (m_reg_h == 0) ? 1 : ((m_reg_h > g4fbw_pkg::REGION_MAX) ?
                               int'(g4fbw_pkg::REGION_MAX) : int'(m_reg_h));
    sw = (m_scr_w > g4fbw_pkg::MAX_SCREEN_WIDTH) ? g4fbw_pkg::MAX_SCREEN_WIDTH
                                                 : int'(m_scr_w);
    sh = (m_scr_h > g4fbw_pkg::MAX_SCREEN_HEIGHT) ? g4fbw_pkg::MAX_SCREEN_HEIGHT
                                                  : int'(m_scr_h);
    if (m_gray16) begin
      g = 4'((int'(b) + 8) / 17);
    end else begin
      g = mono ? g4fbw_pkg::GRAY_WHITE : g4fbw_pkg::GRAY_BLACK;
    end
    xx = int'($signed(m_org_x)) + int'(col_q);
    yy = int'($signed(m_org_y)) + int'(row_q);
    r = '0;
    if (xx >= 0 && yy >= 0 && xx < sw && yy < sh) begin
      a = (yy * (sw / 2) + xx / 2) & ((1 << g4fbw_pkg::FB_AW) - 1);
      v = fb_model[a];
      if (xx[0]) begin
        v = {g, v[3:0]};
      end else begin
        v = {v[7:4], g};
      end
      fb_model[a] = v;
      r.written = 1'b1;
      r.addr = a[g4fbw_pkg::FB_AW-1:0];
      r.value = v;
    end
    col_end = (int'(col_q) + 1 >= rw);
    row_end = (int'(row_q) + 1 >= rh);
    r.last = col_end && row_end;
    if (col_end) begin
      col_q = '0;
      row_q = row_end ? '0 : row_q + 1'b1;
    end else begin
      col_q = col_q + 1'b1;
    end
    return r;
  endfunction

  task automatic add_pixel(input logic [7:0] b, input logic m);
    job_t j;
    j = '0;
    j.kind = JOB_PIXEL;
    j.brightness = b;
    j.mono = m;
    jobs = {jobs, j};
  endtask

  task automatic add_cfg(input logic [g4fbw_pkg::CFG_IDX_W-1:0] idx,
                         input logic [g4fbw_pkg::CFG_W-1:0] data);
    job_t j;
    j = '0;
    j.kind = JOB_CFG;
    j.idx = idx;
    j.data = data;
    jobs = {jobs, j};
  endtask

  task automatic add_drain();
    job_t j;
    j = '0;
    j.kind = JOB_DRAIN;
    jobs = {jobs, j};
  endtask

  task automatic flag_error(input string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endtask

  // Transfers are observed here; predictions are made as each input is taken.
  always @(posedge clk) begin
    fb_update_t got, want;
    in_took  <= !rst && in_valid && !in_stall;
    cfg_took <= !rst && cfg_valid && cfg_ready;
    if (!rst) begin
      if (cfg_valid && cfg_ready) apply_cfg(cfg_index, cfg_data);
      if (in_valid && !in_stall) begin
        pending_updates = {pending_updates, store_pixel(brightness, mono_on)};
      end
      if (out_valid && !out_stall) begin
        got = {written, byte_address, byte_value, last_pixel};
        if (pending_updates.size() == 0) begin
          flag_error($sformatf("unexpected result: written=%0b addr=%h value=%h last=%0b",
                               got.written, got.addr, got.value, got.last));
        end else begin
          want = pending_updates.pop_front();
          if (got !== want) begin
            flag_error($sformatf({"mismatch: expected written=%0b addr=%h value=%h last=%0b,",
                                  " got written=%0b addr=%h value=%h last=%0b"},
                                 want.written, want.addr, want.value, want.last,
                                 got.written, got.addr, got.value, got.last));
          end
        end
      end
    end
  end

  // Sender: pixels go out in bursts; register writes and pauses wait for the pipeline
  // to empty.
  always @(negedge clk) begin
    logic nv_in, nv_cfg;
    job_t j;
    nv_in  = in_valid && !in_took;
    nv_cfg = cfg_valid && !cfg_took;
    if (!rst && !nv_in && !nv_cfg) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (jobs.size() != 0) begin
        j = jobs[0];
        case (j.kind)
          JOB_PIXEL: begin
            void'(jobs.pop_front());
            brightness <= j.brightness;
            mono_on <= j.mono;
            nv_in = 1'b1;
            if (burst_left > 0) begin
              burst_left--;
            end else begin
              burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                       : $urandom_range(1, 20);
              gap_left = $urandom_range(1, 6);
            end
          end
          JOB_CFG: begin
            if (pending_updates.size() == 0) begin
              void'(jobs.pop_front());
              cfg_index <= j.idx;
              cfg_data <= j.data;
              nv_cfg = 1'b1;
            end
          end
          default: begin
            if (pending_updates.size() == 0) void'(jobs.pop_front());
          end
        endcase
      end
    end
    in_valid <= nv_in;
    cfg_valid <= nv_cfg;
  end

  // Receiver back-pressure, switching between randomly chosen patterns.
  always @(negedge clk) begin
    if (sink_left == 0) begin
      sink_mode = sink_mode_t'($urandom_range(0, 3));
      sink_left = $urandom_range(20, 300);
    end else begin
      sink_left--;
    end
    case (sink_mode)
      SINK_FREE:  out_stall <= 1'b0;
      SINK_LIGHT: out_stall <= ($urandom_range(0, 99) < 25);
      SINK_HEAVY: out_stall <= ($urandom_range(0, 99) < 80);
      default:    out_stall <= ((sink_left % 7) < 3);
    endcase
  end

  initial begin
    #4000000;
    $display("tb_top NOT OK");
    $finish;
  end

  initial begin
    int scen, sw, sh, ox, oy, rw, rh, ew, eh, n, rand_pix;

    // Reset settings: a one-pixel region at the origin in black and white.
    add_pixel(8'hFF, 1'b1);
    add_pixel(8'h00, 1'b0);
    add_pixel(8'h55, 1'b1);

    // Gray rounding edges over a 4 by 2 region.
    add_cfg(g4fbw_pkg::REG_GRAY16_ENABLE, g4fbw_pkg::CFG_W'(1));
    add_cfg(g4fbw_pkg::REG_SCREEN_WIDTH, g4fbw_pkg::CFG_W'(8));
    add_cfg(g4fbw_pkg::REG_SCREEN_HEIGHT, g4fbw_pkg::CFG_W'(4));
    add_cfg(g4fbw_pkg::REG_REGION_WIDTH, g4fbw_pkg::CFG_W'(4));
    add_cfg(g4fbw_pkg::REG_REGION_HEIGHT, g4fbw_pkg::CFG_W'(2));
    for (int i = 0; i < 8; i++) add_pixel(GRAY_EDGES[i], 1'b0);

    // Region starting left of the screen; only bit 0 of the mode register counts.
    add_cfg(g4fbw_pkg::REG_GRAY16_ENABLE, g4fbw_pkg::CFG_W'(11'h7FE));
    add_cfg(g4fbw_pkg::REG_ORIGIN_X, g4fbw_pkg::CFG_W'(-2));
    add_cfg(g4fbw_pkg::REG_REGION_WIDTH, g4fbw_pkg::CFG_W'(6));
    add_cfg(g4fbw_pkg::REG_REGION_HEIGHT, g4fbw_pkg::CFG_W'(1));
    add_pixel(8'h3C, 1'b1);
    add_pixel(8'hC3, 1'b0);
    add_pixel(8'h01, 1'b1);
    add_pixel(8'hFE, 1'b1);
    add_pixel(8'h80, 1'b0);
    add_pixel(8'h7F, 1'b1);

    // Odd screen width: the last column shares a byte with the next row.
    add_cfg(g4fbw_pkg::REG_GRAY16_ENABLE, g4fbw_pkg::CFG_W'(1));
    add_cfg(g4fbw_pkg::REG_SCREEN_WIDTH, g4fbw_pkg::CFG_W'(3));
    add_cfg(g4fbw_pkg::REG_SCREEN_HEIGHT, g4fbw_pkg::CFG_W'(2));
    add_cfg(g4fbw_pkg::REG_ORIGIN_X, g4fbw_pkg::CFG_W'(0));
    add_cfg(g4fbw_pkg::REG_REGION_WIDTH, g4fbw_pkg::CFG_W'(3));
    add_cfg(g4fbw_pkg::REG_REGION_HEIGHT, g4fbw_pkg::CFG_W'(2));
    for (int i = 0; i < 6; i++) add_pixel(8'($urandom_range(0, 255)), 1'b0);

    // Geometry writes restart the region mid-way, other writes keep the counters.
    add_cfg(g4fbw_pkg::REG_REGION_WIDTH, g4fbw_pkg::CFG_W'(4));
    add_cfg(g4fbw_pkg::REG_REGION_HEIGHT, g4fbw_pkg::CFG_W'(2));
    add_pixel(8'hAA, 1'b0);
    add_pixel(8'h55, 1'b1);
    add_cfg(g4fbw_pkg::REG_ORIGIN_X, g4fbw_pkg::CFG_W'(1022));
    add_pixel(8'hF0, 1'b1);
    add_cfg(g4fbw_pkg::REG_SCREEN_WIDTH, g4fbw_pkg::CFG_W'(2047));
    add_pixel(8'h0F, 1'b0);
    add_cfg(REG_UNUSED, g4fbw_pkg::CFG_W'(2047));
    add_pixel(8'hFF, 1'b1);

    // Far negative origin, region sizes out of range, empty screen.
    add_cfg(g4fbw_pkg::REG_ORIGIN_Y, g4fbw_pkg::CFG_W'(-1024));
    add_cfg(g4fbw_pkg::REG_REGION_WIDTH, g4fbw_pkg::CFG_W'(0));
    add_cfg(g4fbw_pkg::REG_REGION_HEIGHT, g4fbw_pkg::CFG_W'(2047));
    add_cfg(g4fbw_pkg::REG_SCREEN_HEIGHT, g4fbw_pkg::CFG_W'(0));
    add_cfg(g4fbw_pkg::REG_SCREEN_WIDTH, g4fbw_pkg::CFG_W'(0));
    add_pixel(8'hFF, 1'b1);
    add_pixel(8'h00, 1'b0);
    add_drain();

    rand_pix = 0;
    while (rand_pix < 1800) begin
      scen = $urandom_range(0, 9);
      if (scen < 7) begin
        // Small screens so that bytes are revisited often.
        sw = 2 * $urandom_range(1, 16) + ($urandom_range(0, 7) == 0);
        sh = $urandom_range(1, 16);
        rw = $urandom_range(1, 12);
        rh = $urandom_range(1, 6);
        ox = $urandom_range(0, sw + 6) - 4;
        oy = $urandom_range(0, sh + 6) - 4;
      end else if (scen < 9) begin
        case ($urandom_range(0, 3))
          0: sw = 1024;
          1: sw = 2047;
          2: sw = 960;
          default: sw = $urandom_range(2, 2047);
        endcase
        case ($urandom_range(0, 3))
          0: sh = 1024;
          1: sh = 2047;
          2: sh = 540;
          default: sh = $urandom_range(1, 2047);
        endcase
        rw = $urandom_range(1, 16);
        rh = $urandom_range(1, 4);
        ox = $urandom_range(0, 1) ? ((sw > 1024 ? 1024 : sw) - $urandom_range(0, 20))
                                  : $urandom_range(0, 2047) - 1024;
        oy = $urandom_range(0, 1) ? ((sh > 1024 ? 1024 : sh) - $urandom_range(0, 6))
                                  : $urandom_range(0, 2047) - 1024;
      end else begin
        sw = $urandom_range(0, 2047);
        sh = $urandom_range(0, 2047);
        rw = $urandom_range(0, 2047);
        rh = $urandom_range(0, 2047);
        ox = $urandom_range(0, 2047);
        oy = $urandom_range(0, 2047);
      end
      if ($urandom_range(0, 3) != 0) add_cfg(g4fbw_pkg::REG_SCREEN_WIDTH, g4fbw_pkg::CFG_W'(sw));
      if ($urandom_range(0, 3) != 0) begin
        add_cfg(g4fbw_pkg::REG_SCREEN_HEIGHT, g4fbw_pkg::CFG_W'(sh));
      end
      if ($urandom_range(0, 1) != 0) begin
        add_cfg(g4fbw_pkg::REG_GRAY16_ENABLE,
                g4fbw_pkg::CFG_W'({10'($urandom_range(0, 1023)), 1'($urandom_range(0, 1))}));
      end
      if ($urandom_range(0, 19) == 0) begin
        add_cfg(REG_UNUSED, g4fbw_pkg::CFG_W'($urandom_range(0, 2047)));
      end
      if ($urandom_range(0, 3) != 0) add_cfg(g4fbw_pkg::REG_ORIGIN_X, g4fbw_pkg::CFG_W'(ox));
      if ($urandom_range(0, 3) != 0) add_cfg(g4fbw_pkg::REG_ORIGIN_Y, g4fbw_pkg::CFG_W'(oy));
      // Most phases start a fresh region; the rest carry on from the previous one.
      if ($urandom_range(0, 9) != 0) begin
        add_cfg(g4fbw_pkg::REG_REGION_WIDTH, g4fbw_pkg::CFG_W'(rw));
        add_cfg(g4fbw_pkg::REG_REGION_HEIGHT, g4fbw_pkg::CFG_W'(rh));
      end
      ew = (rw == 0) ? 1 : ((rw > 1024) ? 1024 : rw);
      eh = (rh == 0) ? 1 : ((rh > 1024) ? 1024 : rh);
      n = ew * eh;
      if (n > 96 || $urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 60);
      end else begin
        n = n * $urandom_range(1, 3);
      end
      for (int k = 0; k < n; k++) begin
        add_pixel(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        if (k == n / 2 && $urandom_range(0, 6) == 0) add_drain();
      end
      rand_pix += n;
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (jobs.size() != 0 || in_valid || cfg_valid || pending_updates.size() != 0) begin
      @(posedge clk);
    end
    repeat (20) @(posedge clk);
    if (errors == 0 && pending_updates.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
